// File: hw/rtl/gamut_clip_desaturate_assert.svh
// Assertion macros for the gamut clip block.
// Used by the top level only; needs clk and rst_n in the including scope.
`ifndef GAMUT_CLIP_DESATURATE_ASSERT_SVH
`define GAMUT_CLIP_DESATURATE_ASSERT_SVH
`ifndef SYNTHESIS
`define GCD_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gcd check failed: same-cycle implication");
`define GCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gcd check failed: next-cycle implication");
`else
`define GCD_ASSERT_IMPL(label, ante, cons)
`define GCD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/gcd_pkg.sv
// Shared types, widths and helpers of the gamut clip block.
// No dependencies.
package gcd_pkg;

    localparam int VAL_W     = 24;  // color sample width
    localparam int NUM_W     = 27;  // 3*brightness and corner sums
    localparam int DIF_W     = 25;  // corner spans, channel differences
    localparam int PRD_W     = 52;  // interpolation product
    localparam int GQ_W      = 26;  // grey quotient bits
    localparam int GDEN_W    = 26;  // grey divisor magnitude
    localparam int CFG_IDX_W = 3;
    localparam int FLAG_W    = 2;

    localparam int MODE_LOW_BIT = 0;
    localparam int MODE_UP_BIT  = 1;

    localparam logic [1:0] MODE_OFF   = 2'b00;
    localparam logic [1:0] MODE_RESET = 2'b01;

    localparam logic [FLAG_W-1:0] FLAG_NONE  = 2'b00;
    localparam logic [FLAG_W-1:0] FLAG_LOWER = 2'b01;
    localparam logic [FLAG_W-1:0] FLAG_UPPER = 2'b10;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [DIF_W-1:0] dif_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE,
        REG_LOWER_R,
        REG_LOWER_G,
        REG_LOWER_B,
        REG_UPPER_R,
        REG_UPPER_G,
        REG_UPPER_B
    } cfg_idx_t;

    // Which result the pixel takes
    typedef enum logic [1:0] {
        SEL_PASS,
        SEL_LOWER,
        SEL_UPPER,
        SEL_BLEND
    } sel_t;

    // Per-channel blend factor source
    typedef enum logic [1:0] {
        FAC_ONE,
        FAC_ZERO,
        FAC_DIV
    } fac_t;

    typedef struct packed {
        logic [1:0]      mode;
        val_t [2:0]      lower;
        val_t [2:0]      upper;
    } cfg_t;

    typedef struct packed {
        val_t [2:0]      pix;
        sel_t            sel;
    } item_t;

    typedef struct packed {
        item_t           item;
        logic            den_zero;
        logic [2:0]      neg;
        logic [2:0]      ovf;
    } grey_side_t;

    typedef struct packed {
        item_t           item;
        val_t [2:0]      grey;
        dif_t [2:0]      diff;
        fac_t [2:0]      fac;
        logic [FLAG_W-1:0] flags;
    } fac_side_t;

    function automatic val_t sat_val(input logic signed [63:0] v);
        val_t r;
        if (v > 64'sd8388607)
            r = {1'b0, {(VAL_W-1){1'b1}}};
        else if (v < -64'sd8388608)
            r = {1'b1, {(VAL_W-1){1'b0}}};
        else
            r = v[VAL_W-1:0];
        return r;
    endfunction

endpackage

// File: hw/rtl/gcd_div_pipe.sv
// Pipelined restoring divider: one quotient bit per stage, several lanes
// sharing a sideband word. No package dependency.
module gcd_div_pipe #(
    parameter int LANES  = 3,
    parameter int DEN_W  = 26,
    parameter int Q_W    = 26,
    parameter int SIDE_W = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [LANES-1:0][DEN_W-1:0]      rem,
    input  logic [LANES-1:0][DEN_W-1:0]      den,
    input  logic [LANES-1:0][Q_W-1:0]        dvd,
    input  logic [SIDE_W-1:0]                side_in,
    output logic                             out_valid,
    output logic [LANES-1:0][Q_W-1:0]        quo,
    output logic [SIDE_W-1:0]                side_out
);

    logic                          v_reg [Q_W];
    logic [LANES-1:0][DEN_W-1:0]   r_reg [Q_W];
    logic [LANES-1:0][DEN_W-1:0]   d_reg [Q_W];
    logic [LANES-1:0][Q_W-1:0]     n_reg [Q_W];
    logic [LANES-1:0][Q_W-1:0]     q_reg [Q_W];
    logic [SIDE_W-1:0]             s_reg [Q_W];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic                        v_src;
        logic [LANES-1:0][DEN_W-1:0] r_src;
        logic [LANES-1:0][DEN_W-1:0] d_src;
        logic [LANES-1:0][Q_W-1:0]   n_src;
        logic [LANES-1:0][Q_W-1:0]   q_src;
        logic [SIDE_W-1:0]           s_src;
        logic [LANES-1:0][DEN_W-1:0] r_next;
        logic [LANES-1:0][Q_W-1:0]   n_next;
        logic [LANES-1:0][Q_W-1:0]   q_next;

        if (s == 0) begin : g_first
            assign v_src = in_valid;
            assign r_src = rem;
            assign d_src = den;
            assign n_src = dvd;
            assign q_src = '0;
            assign s_src = side_in;
        end else begin : g_rest
            assign v_src = v_reg[s-1];
            assign r_src = r_reg[s-1];
            assign d_src = d_reg[s-1];
            assign n_src = n_reg[s-1];
            assign q_src = q_reg[s-1];
            assign s_src = s_reg[s-1];
        end

        // Shift in the next dividend bit, subtract when it fits
        always_comb
        begin
            logic [DEN_W:0] t;
            for (int l = 0; l < LANES; l++)
            begin
                t = {r_src[l], n_src[l][Q_W-1]};
                if (t >= {1'b0, d_src[l]})
                begin
                    r_next[l] = DEN_W'(t - {1'b0, d_src[l]});
                    q_next[l] = {q_src[l][Q_W-2:0], 1'b1};
                end
                else
                begin
                    r_next[l] = t[DEN_W-1:0];
                    q_next[l] = {q_src[l][Q_W-2:0], 1'b0};
                end
                n_next[l] = n_src[l] << 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_src;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[s] <= r_next;
                d_reg[s] <= d_src;
                n_reg[s] <= n_next;
                q_reg[s] <= q_next;
                s_reg[s] <= s_src;
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign quo       = q_reg[Q_W-1];
    assign side_out  = s_reg[Q_W-1];

endmodule

// File: hw/rtl/gcd_grey_prep.sv
// Front stages: corner tests, interpolation product and divider operand setup.
// Depends on gcd_pkg.
module gcd_grey_prep (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         en,
    input  gcd_pkg::cfg_t                                cfg,
    input  logic                                         in_valid,
    input  gcd_pkg::val_t                                red,
    input  gcd_pkg::val_t                                green,
    input  gcd_pkg::val_t                                blue,
    input  gcd_pkg::val_t                                brightness,
    output logic                                         dv,
    output logic [2:0][gcd_pkg::GDEN_W-1:0]              d_rem,
    output logic [2:0][gcd_pkg::GDEN_W-1:0]              d_den,
    output logic [2:0][gcd_pkg::GQ_W-1:0]                d_low,
    output gcd_pkg::grey_side_t                          d_side
);
    import gcd_pkg::*;

    // Stage A
    logic signed [NUM_W-1:0] brt3, sl, su;
    sel_t                    sel_next;
    logic                    a_valid_reg;
    item_t                   a_item_reg;
    logic signed [NUM_W-1:0] num_reg, a_den_reg;
    dif_t [2:0]              span_reg;

    assign brt3 = NUM_W'($signed(brightness)) + (NUM_W'($signed(brightness)) <<< 1);
    assign sl = NUM_W'($signed(cfg.lower[0])) + NUM_W'($signed(cfg.lower[1]))
              + NUM_W'($signed(cfg.lower[2]));
    assign su = NUM_W'($signed(cfg.upper[0])) + NUM_W'($signed(cfg.upper[1]))
              + NUM_W'($signed(cfg.upper[2]));

    always_comb
    begin
        if (cfg.mode == MODE_OFF)
            sel_next = SEL_PASS;
        else if (cfg.mode[MODE_LOW_BIT] && (brt3 < sl))
            sel_next = SEL_LOWER;
        else if (cfg.mode[MODE_UP_BIT] && (brt3 > su))
            sel_next = SEL_UPPER;
        else
            sel_next = SEL_BLEND;
    end

    // Stage B
    logic                    b_valid_reg;
    item_t                   b_item_reg;
    logic signed [NUM_W-1:0] b_den_reg;
    logic signed [PRD_W-1:0] prod_reg [3];

    // Stage C
    logic [NUM_W-1:0]        den_abs;
    logic [GDEN_W-1:0]       dm;
    logic [PRD_W-1:0]        nm [3];
    logic [PRD_W-1:0]        np [3];
    logic                    c_valid_reg;
    grey_side_t              c_side_reg;
    logic [2:0][GDEN_W-1:0]  c_rem_reg;
    logic [2:0][GQ_W-1:0]    c_low_reg;
    logic [GDEN_W-1:0]       c_den_reg;

    assign den_abs = b_den_reg[NUM_W-1] ? NUM_W'(-b_den_reg) : NUM_W'(b_den_reg);
    assign dm      = den_abs[GDEN_W-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            nm[i] = prod_reg[i][PRD_W-1] ? PRD_W'(-prod_reg[i]) : PRD_W'(prod_reg[i]);
            // round half away from zero: add half the divisor to the magnitude
            np[i] = nm[i] + PRD_W'(dm >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg.pix[0] <= red;
            a_item_reg.pix[1] <= green;
            a_item_reg.pix[2] <= blue;
            a_item_reg.sel    <= sel_next;
            num_reg           <= brt3 - sl;
            a_den_reg         <= su - sl;
            for (int i = 0; i < 3; i++)
                span_reg[i] <= DIF_W'($signed(cfg.upper[i])) - DIF_W'($signed(cfg.lower[i]));

            b_item_reg <= a_item_reg;
            b_den_reg  <= a_den_reg;
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= PRD_W'(num_reg) * PRD_W'($signed(span_reg[i]));

            c_side_reg.item     <= b_item_reg;
            c_side_reg.den_zero <= (b_den_reg == '0);
            c_den_reg           <= dm;
            for (int i = 0; i < 3; i++)
            begin
                c_side_reg.neg[i] <= prod_reg[i][PRD_W-1] ^ b_den_reg[NUM_W-1];
                c_side_reg.ovf[i] <= (np[i] >= (PRD_W'(dm) << GQ_W));
                c_rem_reg[i]      <= np[i][PRD_W-1:GQ_W];
                c_low_reg[i]      <= np[i][GQ_W-1:0];
            end
        end
    end

    assign dv     = c_valid_reg;
    assign d_rem  = c_rem_reg;
    assign d_low  = c_low_reg;
    assign d_den  = {3{c_den_reg}};
    assign d_side = c_side_reg;

endmodule

// File: hw/rtl/gcd_factor_prep.sv
// Grey assembly, channel limit tests and factor divider operand setup.
// Depends on gcd_pkg.
module gcd_factor_prep (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  gcd_pkg::cfg_t                          cfg,
    input  logic                                   gv,
    input  logic [2:0][gcd_pkg::GQ_W-1:0]          g_quo,
    input  gcd_pkg::grey_side_t                    g_side,
    output logic                                   fv,
    output logic [2:0][gcd_pkg::DIF_W-1:0]         f_rem,
    output logic [2:0][gcd_pkg::DIF_W-1:0]         f_den,
    output gcd_pkg::fac_side_t                     f_side
);
    import gcd_pkg::*;

    // Stage D
    logic [GQ_W:0]            qx [3];
    logic signed [GQ_W+1:0]   qs [3];
    logic signed [GQ_W+2:0]   gsum [3];
    val_t [2:0]               grey_next;
    logic [2:0]               lo_hit, up_hit;
    val_t [2:0]               lim_next;

    logic                     d_valid_reg;
    item_t                    d_item_reg;
    val_t [2:0]               grey_reg;
    val_t [2:0]               lim_reg;
    logic [2:0]               hit_reg;
    logic [FLAG_W-1:0]        d_flags_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            qx[i]   = g_side.ovf[i] ? ((GQ_W+1)'(1) << GQ_W) : {1'b0, g_quo[i]};
            qs[i]   = g_side.neg[i] ? -$signed({1'b0, qx[i]}) : $signed({1'b0, qx[i]});
            gsum[i] = (GQ_W+3)'($signed(cfg.lower[i])) + (GQ_W+3)'(qs[i]);
            grey_next[i] = g_side.den_zero ? cfg.lower[i] : sat_val(64'(gsum[i]));
            // lower test first, upper only when it fails
            lo_hit[i] = cfg.mode[MODE_LOW_BIT]
                      && ($signed(g_side.item.pix[i]) < $signed(cfg.lower[i]));
            up_hit[i] = !lo_hit[i] && cfg.mode[MODE_UP_BIT]
                      && ($signed(g_side.item.pix[i]) > $signed(cfg.upper[i]));
            lim_next[i] = lo_hit[i] ? cfg.lower[i] : cfg.upper[i];
        end
    end

    // Stage E
    dif_t [2:0]               a_dif, b_dif;
    logic [DIF_W-1:0]         am [3];
    logic [DIF_W-1:0]         bm [3];
    fac_t [2:0]               fac_next;

    logic                     e_valid_reg;
    fac_side_t                e_side_reg;
    logic [2:0][DIF_W-1:0]    e_rem_reg, e_den_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_dif[i] = DIF_W'($signed(lim_reg[i])) - DIF_W'($signed(grey_reg[i]));
            b_dif[i] = DIF_W'($signed(d_item_reg.pix[i])) - DIF_W'($signed(grey_reg[i]));
            am[i] = a_dif[i][DIF_W-1] ? DIF_W'(-a_dif[i]) : DIF_W'(a_dif[i]);
            bm[i] = b_dif[i][DIF_W-1] ? DIF_W'(-b_dif[i]) : DIF_W'(b_dif[i]);
            if (!hit_reg[i])
                fac_next[i] = FAC_ONE;
            else if ((b_dif[i] == '0) || (a_dif[i] == '0)
                     || (a_dif[i][DIF_W-1] != b_dif[i][DIF_W-1]))
                fac_next[i] = FAC_ZERO;
            else if (am[i] >= bm[i])
                fac_next[i] = FAC_ONE;
            else
                fac_next[i] = FAC_DIV;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= gv;
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_item_reg  <= g_side.item;
            grey_reg    <= grey_next;
            lim_reg     <= lim_next;
            hit_reg     <= lo_hit | up_hit;
            d_flags_reg <= {|up_hit, |lo_hit};

            e_side_reg.item  <= d_item_reg;
            e_side_reg.grey  <= grey_reg;
            e_side_reg.diff  <= b_dif;
            e_side_reg.fac   <= fac_next;
            e_side_reg.flags <= d_flags_reg;
            for (int i = 0; i < 3; i++)
            begin
                e_rem_reg[i] <= am[i];
                e_den_reg[i] <= bm[i];
            end
        end
    end

    assign fv     = e_valid_reg;
    assign f_rem  = e_rem_reg;
    assign f_den  = e_den_reg;
    assign f_side = e_side_reg;

endmodule

// File: hw/rtl/gcd_blend.sv
// Back stages: factor minimum, blend multiply, rounding and result select.
// Depends on gcd_pkg.
module gcd_blend #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  gcd_pkg::cfg_t                        cfg,
    input  logic                                 fv,
    input  logic [2:0][FRAC_BITS-1:0]            f_quo,
    input  gcd_pkg::fac_side_t                   f_side,
    output logic                                 out_valid,
    output gcd_pkg::val_t                        red_out,
    output gcd_pkg::val_t                        green_out,
    output gcd_pkg::val_t                        blue_out,
    output logic [gcd_pkg::FLAG_W-1:0]           clip_flags
);
    import gcd_pkg::*;

    localparam int FW = FRAC_BITS + 1;
    localparam int PW = FRAC_BITS + 27;
    localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

    // Stage F: per-channel factor, then the smallest
    logic [FW-1:0]      fac_val [3];
    logic [FW-1:0]      min01, vv_next;
    logic               sf_valid_reg;
    fac_side_t          sf_side_reg;
    logic [FW-1:0]      vv_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (f_side.fac[i])
                FAC_ONE:  fac_val[i] = ONE;
                FAC_ZERO: fac_val[i] = '0;
                FAC_DIV:  fac_val[i] = {1'b0, f_quo[i]};
                default:  fac_val[i] = ONE;
            endcase
        end
        min01   = (fac_val[0] < fac_val[1]) ? fac_val[0] : fac_val[1];
        vv_next = (fac_val[2] < min01) ? fac_val[2] : min01;
    end

    // Stage G: scale the pixel-to-grey difference
    logic               sg_valid_reg;
    fac_side_t          sg_side_reg;
    logic signed [PW-1:0] prod_reg [3];

    // Stage H: round, add grey, pick result
    logic [PW-1:0]        pm [3];
    logic [PW-1:0]        rnd [3];
    logic signed [PW:0]   rs [3];
    logic signed [PW:0]   sum [3];
    val_t [2:0]           res_next;
    logic [FLAG_W-1:0]    flags_next;

    logic                 out_valid_reg;
    val_t [2:0]           res_reg;
    logic [FLAG_W-1:0]    flags_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pm[i]  = prod_reg[i][PW-1] ? PW'(-prod_reg[i]) : PW'(prod_reg[i]);
            rnd[i] = (pm[i] + (PW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
            rs[i]  = prod_reg[i][PW-1] ? -$signed({1'b0, rnd[i]}) : $signed({1'b0, rnd[i]});
            sum[i] = (PW+1)'($signed(sg_side_reg.grey[i])) + rs[i];
        end
        case (sg_side_reg.item.sel)
            SEL_PASS:
            begin
                res_next   = sg_side_reg.item.pix;
                flags_next = FLAG_NONE;
            end
            SEL_LOWER:
            begin
                res_next   = cfg.lower;
                flags_next = FLAG_LOWER;
            end
            SEL_UPPER:
            begin
                res_next   = cfg.upper;
                flags_next = FLAG_UPPER;
            end
            SEL_BLEND:
            begin
                flags_next = sg_side_reg.flags;
                if (sg_side_reg.flags == FLAG_NONE)
                    res_next = sg_side_reg.item.pix;
                else
                    for (int i = 0; i < 3; i++)
                        res_next[i] = sat_val(64'(sum[i]));
            end
            default:
            begin
                res_next   = sg_side_reg.item.pix;
                flags_next = FLAG_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_valid_reg  <= 1'b0;
            sg_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            sf_valid_reg  <= fv;
            sg_valid_reg  <= sf_valid_reg;
            out_valid_reg <= sg_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sf_side_reg <= f_side;
            vv_reg      <= vv_next;
            sg_side_reg <= sf_side_reg;
            for (int i = 0; i < 3; i++)
                prod_reg[i] <= PW'($signed({1'b0, vv_reg})) * PW'($signed(sf_side_reg.diff[i]));
            res_reg   <= res_next;
            flags_reg <= flags_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign red_out    = res_reg[0];
    assign green_out  = res_reg[1];
    assign blue_out   = res_reg[2];
    assign clip_flags = flags_reg;

endmodule

// File: hw/rtl/gamut_clip_desaturate.sv
// Top level of the gamut clip block: configuration registers and pipeline.
// Depends on gcd_pkg, gcd_grey_prep, gcd_div_pipe, gcd_factor_prep, gcd_blend
// and the assertion header.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one RGB pixel plus brightness,
//   all signed fixed point with FRAC_BITS fraction bits. Output channel
//   (out_valid/out_ready) returns the clipped pixel and two clip flags.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
//   the clip mode and the two cube corners; it is always ready. Write it
//   only while no pixel is in flight.
//   Throughput: one pixel per cycle while the output is not stalled. On its
//   way to the output port a pixel passes the two bit-per-stage dividers:
//   26 stages for the grey interpolation and FRAC_BITS stages for the blend
//   factor.
//   Stall: the whole pipeline holds while a result waits and out_ready is
//   low; in_ready drops only then, and no transfer is lost or repeated.
//   Reset: all valid bits clear, clip mode returns to lower-only clipping,
//   the lower corner to zero and the upper corner to 1.0.
`include "gamut_clip_desaturate_assert.svh"
module gamut_clip_desaturate #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gcd_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gcd_pkg::VAL_W-1:0]             cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [gcd_pkg::VAL_W-1:0]      red_in,
    input  logic signed [gcd_pkg::VAL_W-1:0]      green_in,
    input  logic signed [gcd_pkg::VAL_W-1:0]      blue_in,
    input  logic signed [gcd_pkg::VAL_W-1:0]      brightness,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [gcd_pkg::VAL_W-1:0]      red_out,
    output logic signed [gcd_pkg::VAL_W-1:0]      green_out,
    output logic signed [gcd_pkg::VAL_W-1:0]      blue_out,
    output logic [gcd_pkg::FLAG_W-1:0]            clip_flags
);
    import gcd_pkg::*;

    localparam val_t UNIT = VAL_W'(64'd1 << FRAC_BITS);

    // Configuration registers
    logic [1:0]   mode_reg;
    val_t [2:0]   lower_reg;
    val_t [2:0]   upper_reg;
    cfg_t         cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RESET;
            lower_reg <= '0;
            upper_reg <= {UNIT, UNIT, UNIT};
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:    mode_reg     <= cfg_data[1:0];
                REG_LOWER_R: lower_reg[0] <= cfg_data;
                REG_LOWER_G: lower_reg[1] <= cfg_data;
                REG_LOWER_B: lower_reg[2] <= cfg_data;
                REG_UPPER_R: upper_reg[0] <= cfg_data;
                REG_UPPER_G: upper_reg[1] <= cfg_data;
                REG_UPPER_B: upper_reg[2] <= cfg_data;
                default:     ;  // drop writes past the register list
            endcase
        end
    end

    assign cfg.mode  = mode_reg;
    assign cfg.lower = lower_reg;
    assign cfg.upper = upper_reg;

    // Global advance: every stage moves unless a finished result is held
    logic en;
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Front: corner decisions and interpolation numerator
    logic                      gd_valid;
    logic [2:0][GDEN_W-1:0]    gd_rem, gd_den;
    logic [2:0][GQ_W-1:0]      gd_low;
    grey_side_t                gd_side;

    gcd_grey_prep u_grey_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .red        (red_in),
        .green      (green_in),
        .blue       (blue_in),
        .brightness (brightness),
        .dv         (gd_valid),
        .d_rem      (gd_rem),
        .d_den      (gd_den),
        .d_low      (gd_low),
        .d_side     (gd_side)
    );

    // Grey interpolation divider
    logic                      gq_valid;
    logic [2:0][GQ_W-1:0]      gq_quo;
    logic [$bits(grey_side_t)-1:0] gq_side_bits;
    grey_side_t                gq_side;

    gcd_div_pipe #(
        .LANES  (3),
        .DEN_W  (GDEN_W),
        .Q_W    (GQ_W),
        .SIDE_W ($bits(grey_side_t))
    ) u_grey_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (gd_valid),
        .rem       (gd_rem),
        .den       (gd_den),
        .dvd       (gd_low),
        .side_in   (gd_side),
        .out_valid (gq_valid),
        .quo       (gq_quo),
        .side_out  (gq_side_bits)
    );

    assign gq_side = gq_side_bits;

    // Grey, limit tests and factor operands
    logic                      fd_valid;
    logic [2:0][DIF_W-1:0]     fd_rem, fd_den;
    fac_side_t                 fd_side;

    gcd_factor_prep u_factor_prep (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .cfg    (cfg),
        .gv     (gq_valid),
        .g_quo  (gq_quo),
        .g_side (gq_side),
        .fv     (fd_valid),
        .f_rem  (fd_rem),
        .f_den  (fd_den),
        .f_side (fd_side)
    );

    // Blend factor divider: numerator magnitude shifted up by FRAC_BITS
    logic                           fq_valid;
    logic [2:0][FRAC_BITS-1:0]      fq_quo;
    logic [$bits(fac_side_t)-1:0]   fq_side_bits;
    fac_side_t                      fq_side;

    gcd_div_pipe #(
        .LANES  (3),
        .DEN_W  (DIF_W),
        .Q_W    (FRAC_BITS),
        .SIDE_W ($bits(fac_side_t))
    ) u_factor_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fd_valid),
        .rem       (fd_rem),
        .den       (fd_den),
        .dvd       ('0),
        .side_in   (fd_side),
        .out_valid (fq_valid),
        .quo       (fq_quo),
        .side_out  (fq_side_bits)
    );

    assign fq_side = fq_side_bits;

    // Blend and output register
    gcd_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .cfg        (cfg),
        .fv         (fq_valid),
        .f_quo      (fq_quo),
        .f_side     (fq_side),
        .out_valid  (out_valid),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .clip_flags (clip_flags)
    );

    // Checks
    `GCD_ASSERT_IMPL(a_ready_when_drained, out_ready, in_ready)
    `GCD_ASSERT_NEXT(a_stall_freezes_pipe, !in_ready, out_valid && $stable(red_out) && $stable(clip_flags))

endmodule
